@@ hdl/constant_verification_table_macros.svh @@
// assertion macros for the constant verification table
// used by the top level only
`ifndef CONSTANT_VERIFICATION_TABLE_MACROS_SVH
`define CONSTANT_VERIFICATION_TABLE_MACROS_SVH

// implication checked every clock outside reset
`define CVT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define CVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/cvt_pkg.sv @@
// package for the constant verification table
// sizes, request codes, the cell control struct and the hit chain struct; no dependencies
`default_nettype none
package cvt_pkg;
    localparam int TableSize = 32;
    localparam int SlotBits = $clog2(TableSize);
    localparam int CountBits = $clog2(TableSize + 1);
    localparam int PredBits = 12;
    localparam int AddrBits = 64;
    localparam int DataBits = 64;

    typedef enum logic [1:0] {
        REQ_VERIFY = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_STORE  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef logic [SlotBits-1:0] slot_t;

    // broadcast to every cell for the request being processed
    typedef struct packed {
        logic               verify;
        logic               store;
        logic               write;
        slot_t              write_slot;
        logic [AddrBits-1:0] vaddr;
        logic [AddrBits-1:0] paddr;
        logic [PredBits-1:0] pred_index;
        logic [DataBits-1:0] load_data;
    } cell_ctrl_t;

    // hit chain handed from cell to cell
    typedef struct packed {
        logic                hit;
        logic [AddrBits-1:0] paddr;
    } hit_chain_t;
endpackage
`default_nettype wire

@@ hdl/cvt_if.sv @@
// valid/ready channel interface, generic payload type
// depends on nothing
`default_nettype none
interface cvt_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hdl/cvt_cell.sv @@
// one table entry: holds its fields, matches the request, forwards the hit chain
// depends on cvt_pkg
`default_nettype none
module cvt_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cvt_pkg::slot_t            slot_id,
    input  wire cvt_pkg::cell_ctrl_t       ctrl,
    input  wire cvt_pkg::hit_chain_t       chain_in,
    output cvt_pkg::hit_chain_t            chain_out,
    output logic                           valid,
    output logic                           store_kill
);
    logic                          valid_reg;
    logic [cvt_pkg::AddrBits-1:0]  vaddr_reg;
    logic [cvt_pkg::AddrBits-1:0]  paddr_reg;
    logic [cvt_pkg::PredBits-1:0]  pidx_reg;
    logic [cvt_pkg::DataBits-1:0]  data_reg;
    logic                          match;
    logic                          wr;

    assign wr = ctrl.write && (ctrl.write_slot == slot_id);
    assign match = valid_reg && (vaddr_reg == ctrl.vaddr) &&
                   (pidx_reg == ctrl.pred_index) && (data_reg == ctrl.load_data);
    assign store_kill = ctrl.store && valid_reg &&
                        ((vaddr_reg == ctrl.vaddr) || (paddr_reg == ctrl.paddr));
    assign valid = valid_reg;

    // first match in index order wins: cells with lower index sit upstream
    always_comb
    begin
        chain_out = chain_in;
        if (!chain_in.hit && ctrl.verify && match)
        begin
            chain_out.hit = 1'b1;
            chain_out.paddr = paddr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr)
        begin
            valid_reg <= 1'b1;
        end
        else if (store_kill)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            vaddr_reg <= ctrl.vaddr;
            paddr_reg <= ctrl.paddr;
            pidx_reg  <= ctrl.pred_index;
            data_reg  <= ctrl.load_data;
        end
    end
endmodule
`default_nettype wire

@@ hdl/cvt_free_list.sv @@
// free slot fifo and lfsr victim picker, pushes freed slots one per cycle; a pop in the same cycle wins over a push
// depends on cvt_pkg
`default_nettype none
module cvt_free_list (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pop,
    input  wire logic                         push,
    input  wire cvt_pkg::slot_t               push_slot,
    output cvt_pkg::slot_t                    alloc_slot,
    output logic [cvt_pkg::CountBits-1:0]     count
);
    localparam int N = cvt_pkg::TableSize;
    localparam int SB = cvt_pkg::SlotBits;

    cvt_pkg::slot_t                fifo_reg [N];
    logic [SB-1:0]                 head_reg;
    logic [cvt_pkg::CountBits-1:0] count_reg;
    logic [15:0]                   lfsr_reg;
    logic [15:0]                   lfsr_next;
    logic [SB-1:0]                 tail;
    logic [cvt_pkg::CountBits:0]   tail_sum;
    logic                          empty;

    assign empty = (count_reg == '0);
    assign lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ 16'hB400) : (lfsr_reg >> 1);
    assign alloc_slot = empty ? SB'(lfsr_next % N) : fifo_reg[head_reg];
    assign tail_sum = (cvt_pkg::CountBits+1)'(head_reg) + (cvt_pkg::CountBits+1)'(count_reg);
    assign tail = SB'(tail_sum % N);
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= cvt_pkg::CountBits'(N);
            lfsr_reg  <= 16'd1;
            for (int i = 0; i < N; i++)
            begin
                fifo_reg[i] <= SB'(i);
            end
        end
        else
        begin
            if (pop && empty)
            begin
                lfsr_reg <= lfsr_next;
            end
            else if (pop)
            begin
                head_reg  <= SB'((head_reg + 1'b1) % N);
                count_reg <= count_reg - 1'b1;
            end
            else if (push)
            begin
                fifo_reg[tail] <= push_slot;
                count_reg <= count_reg + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/constant_verification_table.sv @@
// constant verification table, top level: row of entry cells plus free list
// response: every request type gives a registered result in the cycle after the transfer
// throughput: one transfer per cycle unless rsp stalls; a store that invalidates entries
// then holds off the input while the freed slots enter the free list, one per cycle
// reset: all entries invalid, free list holds every slot in order, lfsr seeded to 1
// depends on cvt_pkg, cvt_if, cvt_cell, cvt_free_list, the macros header
`default_nettype none
`include "constant_verification_table_macros.svh"
module constant_verification_table (
    input wire logic clk,
    input wire logic rst_n,
    cvt_if.sink      req,
    cvt_if.source    rsp
);
    localparam int N = cvt_pkg::TableSize;

    // store invalidation drains here, lowest slot first, one per cycle
    logic [N-1:0]          drain_reg;
    logic [N-1:0]          drain_next;
    logic [N-1:0]          kill;
    logic [N-1:0]          cell_valid;
    logic                  busy;
    logic                  accept;
    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [63:0]           out_paddr_reg;
    logic                  push;
    cvt_pkg::slot_t        push_slot;
    cvt_pkg::slot_t        alloc_slot;
    logic [cvt_pkg::CountBits-1:0] free_cnt;
    cvt_pkg::req_t         rtype;
    cvt_pkg::cell_ctrl_t   ctrl;
    cvt_pkg::hit_chain_t   chain [N+1];

    assign busy = (drain_reg != '0);
    assign req.ready = !busy && (!out_valid_reg || rsp.ready);
    assign accept = req.valid && req.ready;
    assign rtype = cvt_pkg::req_t'(req.payload.req_type);

    // broadcast to the cells
    always_comb
    begin
        ctrl.verify     = accept && (rtype == cvt_pkg::REQ_VERIFY) && req.payload.is_constant;
        ctrl.store      = accept && (rtype == cvt_pkg::REQ_STORE);
        ctrl.write      = accept && (rtype == cvt_pkg::REQ_INSERT);
        ctrl.write_slot = alloc_slot;
        ctrl.vaddr      = req.payload.vaddr;
        ctrl.paddr      = req.payload.paddr;
        ctrl.pred_index = req.payload.pred_index;
        ctrl.load_data  = req.payload.load_data;
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        cvt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .slot_id    (cvt_pkg::SlotBits'(g)),
            .ctrl       (ctrl),
            .chain_in   (chain[g]),
            .chain_out  (chain[g+1]),
            .valid      (cell_valid[g]),
            .store_kill (kill[g])
        );
    end

    // lowest pending slot of the drain vector
    always_comb
    begin
        push_slot = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (drain_reg[i])
            begin
                push_slot = cvt_pkg::SlotBits'(i);
            end
        end
    end
    assign push = busy;
    assign drain_next = drain_reg & (drain_reg - 1'b1);

    cvt_free_list u_free (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (ctrl.write),
        .push       (push),
        .push_slot  (push_slot),
        .alloc_slot (alloc_slot),
        .count      (free_cnt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.store)
            begin
                drain_reg <= kill;
            end
            else if (busy)
            begin
                drain_reg <= drain_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                out_hit_reg   <= chain[N].hit;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_paddr_reg <= chain[N].hit ? chain[N].paddr : 64'd0;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.payload.hit = out_hit_reg;
    assign rsp.payload.hit_paddr = out_paddr_reg;

    // an insert never lands while stores are still freeing slots
    `CVT_ASSERT_IMP(a_no_accept_busy, busy, !req.ready)
    // a pending freed slot is always an invalid entry
    `CVT_ASSERT_IMP(a_drain_invalid, busy, (drain_reg & cell_valid) == '0)
    // free count never exceeds the table size
    `CVT_ASSERT_IMP(a_count_range, 1'b1, free_cnt <= cvt_pkg::CountBits'(N))
    // every accepted request reports a valid result
    `CVT_ASSERT_NEXT(a_hit_valid, accept, rsp.valid)
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// testbench for the constant verification table: random and directed transfers,
// checked against a cycle-free predictor in a scoreboard class
// depends on cvt_pkg, cvt_if and constant_verification_table
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    localparam int ExpDepth = 16;
    localparam int KnownDepth = 64;

    typedef struct packed {
        cvt_pkg::req_t                 req_type;
        logic [cvt_pkg::AddrBits-1:0]  vaddr;
        logic [cvt_pkg::AddrBits-1:0]  paddr;
        logic [cvt_pkg::PredBits-1:0]  pred_index;
        logic [cvt_pkg::DataBits-1:0]  load_data;
        logic                          is_constant;
    } req_item_t;

    typedef struct packed {
        logic                         hit;
        logic [cvt_pkg::AddrBits-1:0] hit_paddr;
    } rsp_item_t;

    // scoreboard: own copy of the table, free list and victim lfsr
    class cvt_scoreboard;
        bit                           slot_valid [cvt_pkg::TableSize];
        logic [cvt_pkg::AddrBits-1:0] slot_vaddr [cvt_pkg::TableSize];
        logic [cvt_pkg::AddrBits-1:0] slot_paddr [cvt_pkg::TableSize];
        logic [cvt_pkg::PredBits-1:0] slot_pidx  [cvt_pkg::TableSize];
        logic [cvt_pkg::DataBits-1:0] slot_data  [cvt_pkg::TableSize];
        int                           free_ring  [cvt_pkg::TableSize];
        int                           free_cnt;
        int                           free_hd;
        logic [15:0]                  lfsr;
        rsp_item_t                    exp_ring [ExpDepth];
        int                           exp_rd;
        int                           exp_wr;
        int                           exp_cnt;
        int                           mismatches;

        function new();
            for (int i = 0; i < cvt_pkg::TableSize; i++)
            begin
                slot_valid[i] = 0;
                free_ring[i] = i;
            end
            free_cnt = cvt_pkg::TableSize;
            free_hd = 0;
            lfsr = 16'd1;
            exp_rd = 0;
            exp_wr = 0;
            exp_cnt = 0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return exp_cnt;
        endfunction

        function int take_slot();
            int s;
            if (free_cnt > 0)
            begin
                s = free_ring[free_hd];
                free_hd = (free_hd + 1) % cvt_pkg::TableSize;
                free_cnt--;
                return s;
            end
            // table full: galois step, then victim by modulo
            if (lfsr[0])
                lfsr = (lfsr >> 1) ^ 16'hB400;
            else
                lfsr = lfsr >> 1;
            return int'(lfsr) % cvt_pkg::TableSize;
        endfunction

        // accepted request: update state, queue the expected response
        function void note_request(req_item_t it);
            rsp_item_t r;
            int s;
            r = '0;
            case (it.req_type)
                cvt_pkg::REQ_VERIFY:
                    if (it.is_constant)
                        for (int i = 0; i < cvt_pkg::TableSize; i++)
                            if (!r.hit && slot_valid[i] && slot_vaddr[i] == it.vaddr &&
                                slot_pidx[i] == it.pred_index && slot_data[i] == it.load_data)
                            begin
                                r.hit = 1'b1;
                                r.hit_paddr = slot_paddr[i];
                            end
                cvt_pkg::REQ_INSERT:
                begin
                    s = take_slot();
                    slot_valid[s] = 1;
                    slot_vaddr[s] = it.vaddr;
                    slot_paddr[s] = it.paddr;
                    slot_pidx[s] = it.pred_index;
                    slot_data[s] = it.load_data;
                end
                cvt_pkg::REQ_STORE:
                    for (int i = 0; i < cvt_pkg::TableSize; i++)
                        if (slot_valid[i] && (slot_vaddr[i] == it.vaddr ||
                                              slot_paddr[i] == it.paddr))
                        begin
                            slot_valid[i] = 0;
                            if (free_cnt < cvt_pkg::TableSize)
                            begin
                                free_ring[(free_hd + free_cnt) % cvt_pkg::TableSize] = i;
                                free_cnt++;
                            end
                        end
                default: ;
            endcase
            if (exp_cnt >= ExpDepth)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("too many responses outstanding");
                return;
            end
            exp_ring[exp_wr] = r;
            exp_wr = (exp_wr + 1) % ExpDepth;
            exp_cnt++;
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t want;
            if (exp_cnt == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response hit=%0b paddr=%h", got.hit, got.hit_paddr);
                return;
            end
            want = exp_ring[exp_rd];
            exp_rd = (exp_rd + 1) % ExpDepth;
            exp_cnt--;
            if (got.hit !== want.hit || got.hit_paddr !== want.hit_paddr)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected hit=%0b paddr=%h, got hit=%0b paddr=%h",
                             want.hit, want.hit_paddr, got.hit, got.hit_paddr);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cvt_if #(.payload_t(req_item_t)) req_ch ();
    cvt_if #(.payload_t(rsp_item_t)) rsp_ch ();

    constant_verification_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always #5 clk = ~clk;

    cvt_scoreboard sb = new();

    // idle cycles drawn per item, 0 up to these limits
    int send_gap_max = 11;
    int recv_gap_max = 11;
    int recv_wait = 0;
    bit hold_off = 0;

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
    end

    // monitor: both channels sampled at the rising edge
    always @(posedge clk)
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.payload);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_response(rsp_ch.payload);
                recv_wait = $urandom_range(0, recv_gap_max);
            end
        end

    // receiver: ready driven once per falling edge
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            rsp_ch.ready <= 1'b0;
        else if (recv_wait > 0)
        begin
            rsp_ch.ready <= 1'b0;
            recv_wait--;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // long receiver stall so the block fills up and back-pressures requests
    initial
    begin
        wait (rst_n);
        repeat (400) @(posedge clk);
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // one request transfer: idle gap, offer, wait for acceptance
    task automatic send_request(req_item_t it);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= it;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_fields(cvt_pkg::req_t op, logic [63:0] va, logic [63:0] pa,
                               logic [11:0] pidx, logic [63:0] data, logic cst);
        req_item_t it;
        it.req_type = op;
        it.vaddr = va;
        it.paddr = pa;
        it.pred_index = pidx;
        it.load_data = data;
        it.is_constant = cst;
        send_request(it);
    endtask

    // recent inserts, reused for hits and for aimed stores
    req_item_t known_ring [KnownDepth];
    int known_wr = 0;
    int known_cnt = 0;
    logic [63:0] alias_va [8];

    task automatic random_request(bit insert_only);
        req_item_t it;
        req_item_t k;
        int r;
        it.vaddr = ($urandom_range(0, 1)) ? alias_va[$urandom_range(0, 7)] : rand64();
        it.paddr = rand64();
        it.pred_index = 12'($urandom());
        it.load_data = rand64();
        it.is_constant = ($urandom_range(0, 9) != 0);
        r = insert_only ? 0 : $urandom_range(0, 99);
        if (r < 35)
        begin
            it.req_type = cvt_pkg::REQ_INSERT;
            known_ring[known_wr] = it;
            known_wr = (known_wr + 1) % KnownDepth;
            if (known_cnt < KnownDepth)
                known_cnt++;
        end
        else if (r < 75)
        begin
            it.req_type = cvt_pkg::REQ_VERIFY;
            if (known_cnt > 0 && $urandom_range(0, 4) != 0)
            begin
                k = known_ring[$urandom_range(0, known_cnt - 1)];
                it.vaddr = k.vaddr;
                it.pred_index = k.pred_index;
                it.load_data = k.load_data;
                // occasionally break one field for a near miss
                case ($urandom_range(0, 7))
                    0: it.vaddr[$urandom_range(0, 63)] ^= 1'b1;
                    1: it.pred_index[$urandom_range(0, 11)] ^= 1'b1;
                    2: it.load_data[$urandom_range(0, 63)] ^= 1'b1;
                    default: ;
                endcase
            end
        end
        else if (r < 93)
        begin
            it.req_type = cvt_pkg::REQ_STORE;
            if (known_cnt > 0 && $urandom_range(0, 9) < 7)
            begin
                k = known_ring[$urandom_range(0, known_cnt - 1)];
                if ($urandom_range(0, 1))
                    it.vaddr = k.vaddr;
                else
                    it.paddr = k.paddr;
            end
        end
        else
            it.req_type = cvt_pkg::REQ_NONE;
        send_request(it);
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            alias_va[i] = rand64();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, every request code, multi-match store
        send_fields(cvt_pkg::REQ_VERIFY, '1, '1, '1, '1, 1'b1);
        send_fields(cvt_pkg::REQ_INSERT, '1, '1, '1, '1, 1'b0);
        send_fields(cvt_pkg::REQ_INSERT, '0, '0, '0, '0, 1'b1);
        send_fields(cvt_pkg::REQ_VERIFY, '1, '0, '1, '1, 1'b1);
        send_fields(cvt_pkg::REQ_VERIFY, '0, '1, '0, '0, 1'b1);
        send_fields(cvt_pkg::REQ_VERIFY, '1, '0, '1, '1, 1'b0);
        send_fields(cvt_pkg::REQ_VERIFY, '1, '0, 12'h7FF, '1, 1'b1);
        send_fields(cvt_pkg::REQ_VERIFY, '1, '0, '1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_fields(cvt_pkg::REQ_NONE, '1, '1, '1, '1, 1'b1);
        send_fields(cvt_pkg::REQ_INSERT, 64'h1234, 64'hAAAA, 12'h5A5, 64'h55, 1'b0);
        send_fields(cvt_pkg::REQ_INSERT, 64'h1234, 64'hBBBB, 12'h5A5, 64'h55, 1'b0);
        send_fields(cvt_pkg::REQ_VERIFY, 64'h1234, '0, 12'h5A5, 64'h55, 1'b1);
        send_fields(cvt_pkg::REQ_STORE, 64'h1234, 64'h9999, '0, '0, 1'b0);
        send_fields(cvt_pkg::REQ_VERIFY, 64'h1234, '0, 12'h5A5, 64'h55, 1'b1);
        send_fields(cvt_pkg::REQ_STORE, 64'h42, '0, '0, '0, 1'b0);
        send_fields(cvt_pkg::REQ_VERIFY, '0, '0, '0, '0, 1'b1);
        send_fields(cvt_pkg::REQ_STORE, 64'h42, '1, '0, '0, 1'b0);
        send_fields(cvt_pkg::REQ_VERIFY, '1, '0, '1, '1, 1'b1);

        // random part, with insert bursts that overflow the free list
        for (int n = 0; n < 1200; n++)
            random_request(n % 200 >= 150 && n % 200 < 190);
        req_ch.valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/cvt_pkg.sv
hdl/cvt_if.sv
hdl/cvt_cell.sv
hdl/cvt_free_list.sv
hdl/constant_verification_table.sv
test/tb_top.sv
